// ===== src/ctu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctu_pkg
// Shared types and constants of the closed-form tetrahedron update pipeline.
// ----------------------------------------------------------------------------
package ctu_pkg;

  localparam int TIME_BITS       = 32;
  localparam int SLOW_BITS       = 24;
  localparam int H_BITS          = 16;
  localparam int SH_BITS         = 24;
  localparam int SQ_BITS         = 2 * SH_BITS;
  localparam int REM_BITS        = SH_BITS + 3;
  localparam int SQRT_PER_STAGE  = 2;
  localparam int SQRT_STAGES     = SH_BITS / SQRT_PER_STAGE;
  localparam int FRONT_STAGES    = 3;
  localparam int PIPE_LAT        = FRONT_STAGES + SQRT_STAGES + 1;
  localparam logic [H_BITS-1:0] H_RESET = 16'd256;

  typedef struct packed {
    logic [TIME_BITS-1:0] time_base;
    logic [TIME_BITS-1:0] time_first;
    logic [TIME_BITS-1:0] time_second;
    logic [SLOW_BITS-1:0] slowness;
  } in_item_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] new_time;
    logic                 finite;
  } out_item_t;

  // item travelling through the square-root stages
  typedef struct packed {
    logic                 ok;
    logic [TIME_BITS-1:0] u0;
    logic [SH_BITS:0]     dsum;
    logic [SQ_BITS-1:0]   rad;
    logic [REM_BITS-1:0]  rem;
    logic [SH_BITS-1:0]   root;
  } sq_item_t;

endpackage
`default_nettype wire

// ===== src/ctu_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctu_front
// Three stages: scaled step and differences, squares, radicand and its sign.
// ----------------------------------------------------------------------------
module ctu_front (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_vld,
  input  wire ctu_pkg::in_item_t        in_item,
  input  wire logic [ctu_pkg::H_BITS-1:0] h,
  output logic                          out_vld,
  output ctu_pkg::sq_item_t             out_item
);
  import ctu_pkg::*;

  logic                   a_vld_r, b_vld_r, c_vld_r;
  logic                   a_ok_r, b_ok_r;
  logic [SH_BITS-1:0]     a_sh_r;
  logic [TIME_BITS-1:0]   a_u0_r, b_u0_r, a_d1_r, a_d2_r;
  logic [SQ_BITS-1:0]     b_sh2_r, b_d1sq_r, b_d2sq_r;
  logic [SH_BITS:0]       b_dsum_r;
  sq_item_t               c_item_r;

  logic [SLOW_BITS+H_BITS-1:0] sh_full;
  logic [SQ_BITS+1:0]          q_full;
  logic                        a_ok_nxt, b_ok_nxt, c_ok_nxt;

  // stage a: s*h and the two differences
  always_comb begin
    sh_full  = in_item.slowness * h;
    a_ok_nxt = (in_item.time_first <= in_item.time_base) &&
               (in_item.time_second <= in_item.time_base);
  end

  // stage b: reject large differences, then square
  always_comb begin
    b_ok_nxt = a_ok_r && (a_d1_r <= {{(TIME_BITS-SH_BITS){1'b0}}, a_sh_r}) &&
               (a_d2_r <= {{(TIME_BITS-SH_BITS){1'b0}}, a_sh_r});
  end

  // stage c: radicand must be strictly positive
  always_comb begin
    q_full   = {2'b00, b_sh2_r} - {2'b00, b_d1sq_r} - {2'b00, b_d2sq_r};
    c_ok_nxt = b_ok_r && !q_full[SQ_BITS+1] && (q_full != '0);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    a_ok_r   <= a_ok_nxt;
    a_sh_r   <= sh_full[SLOW_BITS+H_BITS-1:H_BITS];
    a_u0_r   <= in_item.time_base;
    a_d1_r   <= in_item.time_base - in_item.time_first;
    a_d2_r   <= in_item.time_base - in_item.time_second;

    b_ok_r   <= b_ok_nxt;
    b_u0_r   <= a_u0_r;
    b_sh2_r  <= a_sh_r * a_sh_r;
    b_d1sq_r <= a_d1_r[SH_BITS-1:0] * a_d1_r[SH_BITS-1:0];
    b_d2sq_r <= a_d2_r[SH_BITS-1:0] * a_d2_r[SH_BITS-1:0];
    b_dsum_r <= {1'b0, a_d1_r[SH_BITS-1:0]} + {1'b0, a_d2_r[SH_BITS-1:0]};

    c_item_r.ok   <= c_ok_nxt;
    c_item_r.u0   <= b_u0_r;
    c_item_r.dsum <= b_dsum_r;
    c_item_r.rad  <= q_full[SQ_BITS-1:0];
    c_item_r.rem  <= '0;
    c_item_r.root <= '0;
  end

  assign out_vld  = c_vld_r;
  assign out_item = c_item_r;

endmodule
`default_nettype wire

// ===== src/ctu_sqrt_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctu_sqrt_stage
// Two restoring square-root digit steps followed by a register.
// ----------------------------------------------------------------------------
module ctu_sqrt_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_vld,
  input  wire ctu_pkg::sq_item_t in_item,
  output logic                   out_vld,
  output ctu_pkg::sq_item_t      out_item
);
  import ctu_pkg::*;

  logic      vld_r;
  sq_item_t  item_r, item_nxt;
  logic [REM_BITS-1:0] rem_sh, trial;

  // one result bit per step
  always_comb begin
    item_nxt = in_item;
    rem_sh   = '0;
    trial    = '0;
    for (int k = 0; k < SQRT_PER_STAGE; k++) begin
      rem_sh = {item_nxt.rem[REM_BITS-3:0], item_nxt.rad[SQ_BITS-1:SQ_BITS-2]};
      trial  = {1'b0, item_nxt.root, 2'b01};
      item_nxt.rad = {item_nxt.rad[SQ_BITS-3:0], 2'b00};
      if (rem_sh >= trial) begin
        item_nxt.rem  = rem_sh - trial;
        item_nxt.root = {item_nxt.root[SH_BITS-2:0], 1'b1};
      end else begin
        item_nxt.rem  = rem_sh;
        item_nxt.root = {item_nxt.root[SH_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign out_vld  = vld_r;
  assign out_item = item_r;

endmodule
`default_nettype wire

// ===== src/ctu_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctu_back
// Simplex test, final add with overflow check and output register.
// ----------------------------------------------------------------------------
module ctu_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_vld,
  input  wire ctu_pkg::sq_item_t in_item,
  output logic                   out_vld,
  output ctu_pkg::out_item_t     out_item
);
  import ctu_pkg::*;

  logic               vld_r;
  out_item_t          item_r, item_nxt;
  logic [TIME_BITS:0] t_sum;
  logic               ok;

  // minimiser inside simplex and no overflow
  always_comb begin
    t_sum = {1'b0, in_item.u0} + {{(TIME_BITS+1-SH_BITS){1'b0}}, in_item.root};
    ok    = in_item.ok && (in_item.dsum <= {1'b0, in_item.root}) && !t_sum[TIME_BITS];
    item_nxt.finite   = ok;
    item_nxt.new_time = ok ? t_sum[TIME_BITS-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign out_vld  = vld_r;
  assign out_item = item_r;

endmodule
`default_nettype wire

// ===== src/closed_form_tetra_update_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// closed_form_tetra_update_top
// One update accepted every cycle.
// Three front stages (step, squares, radicand), twelve square-root stages at
// two root bits each, one output stage. busy stays low; results cannot stall.
// Synchronous reset clears all valid bits and sets grid spacing to 256.
// ----------------------------------------------------------------------------
module closed_form_tetra_update_top (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire ctu_pkg::in_item_t         in_data,
  output logic                           out_valid,
  output ctu_pkg::out_item_t             out_data,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [ctu_pkg::H_BITS-1:0] cfg_data
);
  import ctu_pkg::*;

  logic [H_BITS-1:0] h_r;
  logic              sq_vld [SQRT_STAGES+1];
  sq_item_t          sq_item [SQRT_STAGES+1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // grid spacing register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r <= H_RESET;
    end else if (cfg_valid && cfg_ready) begin
      h_r <= cfg_data;
    end
  end

  ctu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start && !busy),
    .in_item  (in_data),
    .h        (h_r),
    .out_vld  (sq_vld[0]),
    .out_item (sq_item[0])
  );

  // square-root chain
  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
    ctu_sqrt_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (sq_vld[g]),
      .in_item  (sq_item[g]),
      .out_vld  (sq_vld[g+1]),
      .out_item (sq_item[g+1])
    );
  end

  ctu_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (sq_vld[SQRT_STAGES]),
    .in_item  (sq_item[SQRT_STAGES]),
    .out_vld  (out_valid),
    .out_item (out_data)
  );

endmodule
`default_nettype wire

// ===== src/ctu_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctu_checker
// Port-level checks of the update pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module ctu_checker (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic                  busy,
  input  wire logic                  out_valid,
  input  wire ctu_pkg::out_item_t    out_data
);
  import ctu_pkg::*;

  // every transfer in gives exactly one result after the pipeline latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n, PIPE_LAT) && $past(rst_n)) |->
      (out_valid == $past(start && !busy, PIPE_LAT)))
    else $error("result strobe does not match accepted item");

  // no result without an earlier accepted item
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_LAT))
    else $error("result strobe without transfer in");

  // rejected update reports zero time
  a_inf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.finite) |-> (out_data.new_time == '0))
    else $error("infinite result with nonzero time");

  // out of reset, the pipeline is empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

endmodule

bind closed_form_tetra_update_top ctu_checker u_ctu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives eikonal tetrahedron updates into the closed-form pipeline, computes
// each expected arrival time with an exact integer square root, and compares
// every result against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb;
  import ctu_pkg::*;

  localparam int LATENCY   = PIPE_LAT;
  localparam int MAX_CYCLE = 600000;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  in_item_t            in_data;
  logic                out_valid;
  out_item_t           out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [H_BITS-1:0]   cfg_data;

  logic [H_BITS-1:0]   spacing;
  out_item_t           pending_times[$];
  int                  n_errors;
  int                  n_sent;
  int                  n_finite;
  int                  n_results;
  int                  cycle;
  bit                  calm;

  closed_form_tetra_update_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLE) begin
      $display("tb: timeout");
      $display("tb: done, errors");
      $finish;
    end
  end

  // floor square root, bit by bit
  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // predicted tetrahedron update
  function automatic out_item_t arrival_update(input in_item_t it);
    out_item_t   res;
    logic [63:0] u0, u1, u2, sh, d1, d2, sh2, rem, r, t;
    res = '0;
    u0 = it.time_base;
    u1 = it.time_first;
    u2 = it.time_second;
    sh = (64'(it.slowness) * 64'(spacing)) >> 16;
    if (u1 > u0 || u2 > u0) return res;
    d1 = u0 - u1;
    d2 = u0 - u2;
    if (d1 > sh || d2 > sh) return res;
    sh2 = sh * sh;
    if (d1 * d1 > sh2) return res;
    rem = sh2 - d1 * d1;
    if (d2 * d2 >= rem) return res;
    r = floor_root(rem - d2 * d2);
    if (d1 + d2 > r) return res;
    t = u0 + r;
    if (t > 64'hFFFF_FFFF) return res;
    res.new_time = t[31:0];
    res.finite = 1'b1;
    return res;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      n_results++;
      if (pending_times.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time,
                 out_data);
        n_errors++;
      end else begin
        out_item_t exp_r;
        exp_r = pending_times.pop_front();
        if (out_data.finite !== exp_r.finite) begin
          $display("%0t: finite expected %b actual %b", $time, exp_r.finite,
                   out_data.finite);
          n_errors++;
        end
        if (out_data.new_time !== exp_r.new_time) begin
          $display("%0t: new_time expected %h actual %h", $time,
                   exp_r.new_time, out_data.new_time);
          n_errors++;
        end
        if (exp_r.finite) n_finite++;
      end
    end
  end

  task automatic idle_gap();
    int n;
    if (!calm && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 13);
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // one update transfer
  task automatic send_update(input in_item_t it);
    idle_gap();
    start   <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_times.push_back(arrival_update(it));
    n_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_times.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_spacing(input logic [H_BITS-1:0] h);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= h;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    spacing = h;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t make_update(input logic [31:0] u0,
      input logic [31:0] u1, input logic [31:0] u2, input logic [23:0] s);
    in_item_t it;
    it.time_base = u0;
    it.time_first = u1;
    it.time_second = u2;
    it.slowness = s;
    return it;
  endfunction

  // well-formed update: differences small against the scaled step
  function automatic in_item_t plausible_update();
    logic [63:0] sh;
    logic [31:0] u0, d1, d2, lim;
    logic [23:0] s;
    s = 24'($urandom);
    if ($urandom_range(0, 3) == 0) s = 24'($urandom_range(0, 255));
    sh = (64'(s) * 64'(spacing)) >> 16;
    lim = (sh > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sh[31:0];
    lim = lim >> $urandom_range(0, 3);
    d1 = $urandom_range(0, lim);
    d2 = $urandom_range(0, lim);
    u0 = $urandom;
    if ($urandom_range(0, 7) == 0) u0 = 32'hFFFF_FFFF - $urandom_range(0, lim);
    if (u0 < d1) d1 = u0;
    if (u0 < d2) d2 = u0;
    return make_update(u0, u0 - d1, u0 - d2, s);
  endfunction

  task automatic test_reset_spacing();
    send_update(make_update(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                            24'h01_0000));
    send_update(make_update(32'h0, 32'h0, 32'h0, 24'h0));
    send_update(make_update(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            24'hFF_FFFF));
  endtask

  task automatic test_special_cases();
    write_spacing(16'hFFFF);
    // negative differences
    send_update(make_update(32'h10, 32'h11, 32'h10, 24'h10_0000));
    send_update(make_update(32'h10, 32'h10, 32'h11, 24'h10_0000));
    // zero slowness, no radicand
    send_update(make_update(32'h100, 32'h100, 32'h100, 24'h0));
    // minimiser outside simplex
    send_update(make_update(32'h8000, 32'h4000, 32'h4000, 24'h00_8000));
    // zero radicand at the top of the time range, then result overflow
    send_update(make_update(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            24'h00_0001));
    send_update(make_update(32'hFFF0_0000, 32'hFFF0_0000, 32'hFFF0_0000,
                            24'hFF_FFFF));
    // small differences, accepted; then large differences, rejected
    send_update(make_update(32'h0010_0000, 32'h000F_F000, 32'h000F_F800,
                            24'h02_0000));
    send_update(make_update(32'hFFFF_FFFF, 32'h0, 32'h0, 24'hFF_FFFF));
    write_spacing(16'd1);
    send_update(make_update(32'h5, 32'h5, 32'h5, 24'hFF_FFFF));
    send_update(make_update(32'h5, 32'h5, 32'h5, 24'h1));
  endtask

  task automatic random_phase(input int n, input logic [H_BITS-1:0] h);
    write_spacing(h);
    repeat (n) begin
      if ($urandom_range(0, 4) == 0)
        send_update(make_update($urandom, $urandom, $urandom, 24'($urandom)));
      else
        send_update(plausible_update());
    end
  endtask

  task automatic test_random();
    random_phase(200, 16'd256);
    random_phase(200, 16'hFFFF);
    random_phase(150, 16'd1);
    random_phase(200, 16'($urandom_range(1, 65535)));
    random_phase(200, 16'($urandom_range(1, 65535)));
    calm = 1'b1;
    random_phase(180, 16'h8000);
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    spacing = H_RESET;
    n_errors = 0;
    n_sent = 0;
    n_finite = 0;
    n_results = 0;
    cycle = 0;
    calm = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_spacing();
    test_special_cases();
    test_random();
    drain();
    $display("tb: %0d updates sent, %0d results checked, %0d finite", n_sent,
             n_results, n_finite);
    $display("tb: spacings covered reset, 1, 65535 and random values");
    if (n_errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
